// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define FWRR_ASSERT(lbl, clk_s, rst_s, prop) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (prop)) \
        else $error("assertion failed");
`define FWRR_ASSERT_ALWAYS(lbl, clk_s, prop) \
    lbl: assert property (@(posedge clk_s) (prop)) \
        else $error("assertion failed");
`else
`define FWRR_ASSERT(lbl, clk_s, rst_s, prop)
`define FWRR_ASSERT_ALWAYS(lbl, clk_s, prop)
`endif
`endif

// ===== rtl/fwrr_pkg.sv =====
// Shared codes and widths of the fiber scheduler.
`default_nettype none
package fwrr_pkg;
    localparam int CMD_W = 3;
    localparam logic [CMD_W-1:0] CMD_TICK    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_EVENT   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SLEEP   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_WAIT    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CREATE  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 3'd5;
    localparam logic [CMD_W-1:0] CMD_YIELD   = 3'd6;

    localparam int TAG_W = 3;
    localparam logic [TAG_W-1:0] Q_RUN   = 3'd0;
    localparam logic [TAG_W-1:0] Q_SLEEP = 3'd1;
    localparam logic [TAG_W-1:0] Q_WAIT  = 3'd2;
    localparam logic [TAG_W-1:0] Q_FREE  = 3'd3;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_TICK_PERIOD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NOTIFY_ID   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NOTIFY_ONE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WILD_SRC    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WILD_VAL    = 3'd4;

    localparam int CFG_W = 16;
    localparam int PERIOD_W = 10;
    localparam int ID_W = 16;
    localparam int CTX_W = 32;
    localparam int SLOT_OUT_W = 4;
    localparam int WOKEN_OUT_W = 5;
endpackage
`default_nettype wire

// ===== rtl/fiber_wake_and_round_robin_scheduler.sv =====
// Fiber scheduler top level: queue memory, walker and rescheduler.
//
// channel | dir | handshake          | payload
// in      | in  | in_valid/in_ready  | cmd sleep_ms event_source event_value data_ready
// out     | out | out_valid/out_ready| status running_slot running_idle woken_count
//         |     |                    | created_slot run_queue_empty
// cfg     | in  | cfg_we             | cfg_index cfg_wdata
//
// Tick and event walk their queue slot by slot; a woken slot is unlinked
// and appended before the walk goes on. The slot memory has one read and
// one write port, which serializes the steps.
// Reset: a clearing pass over every slot rebuilds the free chain;
// no request is taken during it.
// One request at a time; the next is taken while a result waits, and the
// walker stalls in its final step until the output register is free.
`default_nettype none
`include "assert_macros.svh"
module fiber_wake_and_round_robin_scheduler #(
    parameter int FIBER_SLOTS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [2:0]  cmd,
    input  wire logic [31:0] sleep_ms,
    input  wire logic [15:0] event_source,
    input  wire logic [15:0] event_value,
    input  wire logic        data_ready,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             status,
    output logic [3:0]       running_slot,
    output logic             running_idle,
    output logic [4:0]       woken_count,
    output logic [3:0]       created_slot,
    output logic             run_queue_empty,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_wdata
);
    localparam int SW = $clog2(FIBER_SLOTS);
    localparam int LW = $clog2(FIBER_SLOTS + 1);
    localparam int CW = $clog2(FIBER_SLOTS + 1);
    localparam logic [LW-1:0] NIL = LW'(FIBER_SLOTS);
    localparam logic [SW-1:0] LAST = SW'(FIBER_SLOTS - 1);
    // queue numbers as indexes of the head and tail registers
    localparam logic [1:0] QI_RUN   = fwrr_pkg::Q_RUN[1:0];
    localparam logic [1:0] QI_SLEEP = fwrr_pkg::Q_SLEEP[1:0];
    localparam logic [1:0] QI_WAIT  = fwrr_pkg::Q_WAIT[1:0];
    localparam logic [1:0] QI_FREE  = fwrr_pkg::Q_FREE[1:0];

    typedef struct packed {
        logic [LW-1:0]                nxt;
        logic [LW-1:0]                prv;
        logic [fwrr_pkg::TAG_W-1:0]   tag;
        logic [fwrr_pkg::CTX_W-1:0]   ctx;
    } ent_t;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_GO, S_WALK, S_WDEC, S_MRD, S_MDEC,
        S_DT1, S_DT2, S_AP1, S_AP2, S_RESCH, S_RSDEC, S_OUT
    } state_t;

    state_t state_reg;
    logic [SW-1:0] clr_reg;
    logic [2:0] cmd_reg;
    logic [31:0] sleep_reg;
    logic [15:0] src_reg, val_reg;
    logic dr_reg;
    logic [fwrr_pkg::PERIOD_W-1:0] period_reg;
    logic [15:0] nid_reg, n1_reg, wsrc_reg, wval_reg;
    logic [LW-1:0] head_reg [4];
    logic [LW-1:0] tail_reg [4];
    logic [SW-1:0] cur_reg;
    logic idle_reg;
    logic [31:0] tick_reg;
    logic [LW-1:0] f_reg, s_reg, p_reg, n_reg;
    logic [1:0] q_reg;
    logic [CW-1:0] woken_reg;
    logic one_reg, status_reg;
    logic [SW-1:0] created_reg;

    // slot memory, synchronous read, per-field write enables
    ent_t mem [FIBER_SLOTS];
    ent_t rdata;
    logic [SW-1:0] raddr, waddr;
    ent_t wdata;
    logic we_nxt, we_prv, we_tag, we_ctx;

    logic [1:0] aq;
    logic [31:0] ctx_val;
    logic [15:0] ev_id, ev_wv;
    logic vmatch, one_path, wake;

    always_ff @(posedge clk)
    begin
        if (we_nxt) mem[waddr].nxt <= wdata.nxt;
        if (we_prv) mem[waddr].prv <= wdata.prv;
        if (we_tag) mem[waddr].tag <= wdata.tag;
        if (we_ctx) mem[waddr].ctx <= wdata.ctx;
        rdata <= mem[raddr];
    end

    assign in_ready = (state_reg == S_IDLE);

    // target queue of the append step
    always_comb
    begin
        unique case (cmd_reg)
            fwrr_pkg::CMD_SLEEP:   aq = QI_SLEEP;
            fwrr_pkg::CMD_WAIT:    aq = QI_WAIT;
            fwrr_pkg::CMD_RELEASE: aq = QI_FREE;
            default:               aq = QI_RUN;
        endcase
        ctx_val = (cmd_reg == fwrr_pkg::CMD_SLEEP) ? tick_reg + sleep_reg
                                                   : {val_reg, src_reg};
    end

    // wake decision for the walked slot
    always_comb
    begin
        ev_id = rdata.ctx[15:0];
        ev_wv = rdata.ctx[31:16];
        vmatch = (ev_wv == wval_reg) || (ev_wv == val_reg);
        one_path = (src_reg == n1_reg) && (ev_id == nid_reg) && vmatch;
        if (cmd_reg == fwrr_pkg::CMD_TICK)
            wake = (tick_reg >= rdata.ctx);
        else if (one_path)
            wake = !one_reg;
        else
            wake = ((ev_id == wsrc_reg) || (ev_id == src_reg)) && vmatch;
    end

    always_comb
    begin
        unique case (state_reg)
            S_WALK:  raddr = f_reg[SW-1:0];
            S_RESCH: raddr = cur_reg;
            default: raddr = s_reg[SW-1:0];
        endcase
        we_nxt = 1'b0;
        we_prv = 1'b0;
        we_tag = 1'b0;
        we_ctx = 1'b0;
        waddr = s_reg[SW-1:0];
        wdata = '{nxt: NIL, prv: NIL, tag: fwrr_pkg::Q_FREE, ctx: ctx_val};
        unique case (state_reg)
            S_CLEAR:
            begin
                waddr = clr_reg;
                we_nxt = 1'b1;
                we_prv = 1'b1;
                we_tag = 1'b1;
                we_ctx = 1'b1;
                wdata.ctx = '0;
                wdata.nxt = (clr_reg == '0 || clr_reg == LAST)
                          ? NIL : LW'(clr_reg) + LW'(1);
                wdata.prv = (clr_reg > SW'(1)) ? LW'(clr_reg) - LW'(1) : NIL;
                wdata.tag = (clr_reg == '0) ? fwrr_pkg::Q_RUN : fwrr_pkg::Q_FREE;
            end
            S_DT1:
            begin
                waddr = p_reg[SW-1:0];
                we_nxt = (p_reg != NIL);
                wdata.nxt = n_reg;
            end
            S_DT2:
            begin
                waddr = n_reg[SW-1:0];
                we_prv = (n_reg != NIL);
                wdata.prv = p_reg;
            end
            S_AP1:
            begin
                we_nxt = 1'b1;
                we_prv = 1'b1;
                we_tag = 1'b1;
                we_ctx = (cmd_reg == fwrr_pkg::CMD_SLEEP) ||
                         (cmd_reg == fwrr_pkg::CMD_WAIT);
                wdata.prv = tail_reg[aq];
                wdata.tag = {1'b0, aq};
            end
            S_AP2:
            begin
                waddr = p_reg[SW-1:0];
                we_nxt = (p_reg != NIL);
                wdata.nxt = s_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg <= '0;
            period_reg <= 10'd6;
            nid_reg <= 16'd1023;
            n1_reg <= 16'd1022;
            wsrc_reg <= '0;
            wval_reg <= '0;
            head_reg[QI_RUN] <= '0;
            tail_reg[QI_RUN] <= '0;
            head_reg[QI_SLEEP] <= NIL;
            tail_reg[QI_SLEEP] <= NIL;
            head_reg[QI_WAIT] <= NIL;
            tail_reg[QI_WAIT] <= NIL;
            head_reg[QI_FREE] <= LW'(1);
            tail_reg[QI_FREE] <= LW'(FIBER_SLOTS - 1);
            cur_reg <= '0;
            idle_reg <= 1'b0;
            tick_reg <= '0;
            out_valid <= 1'b0;
            cmd_reg <= '0;
            sleep_reg <= '0;
            src_reg <= '0;
            val_reg <= '0;
            dr_reg <= 1'b0;
            f_reg <= NIL;
            s_reg <= NIL;
            p_reg <= NIL;
            n_reg <= NIL;
            q_reg <= '0;
            woken_reg <= '0;
            one_reg <= 1'b0;
            status_reg <= 1'b0;
            created_reg <= '0;
            status <= 1'b0;
            running_slot <= '0;
            running_idle <= 1'b0;
            woken_count <= '0;
            created_slot <= '0;
            run_queue_empty <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    fwrr_pkg::REG_TICK_PERIOD: period_reg <= cfg_wdata[9:0];
                    fwrr_pkg::REG_NOTIFY_ID:   nid_reg <= cfg_wdata;
                    fwrr_pkg::REG_NOTIFY_ONE:  n1_reg <= cfg_wdata;
                    fwrr_pkg::REG_WILD_SRC:    wsrc_reg <= cfg_wdata;
                    fwrr_pkg::REG_WILD_VAL:    wval_reg <= cfg_wdata;
                    default:
                    begin
                    end
                endcase
            end
            // the output step reloads the register itself
            if (out_valid && out_ready && state_reg != S_OUT)
                out_valid <= 1'b0;
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + SW'(1);
                    if (clr_reg == LAST)
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        cmd_reg <= cmd;
                        sleep_reg <= sleep_ms;
                        src_reg <= event_source;
                        val_reg <= event_value;
                        dr_reg <= data_ready;
                        woken_reg <= '0;
                        one_reg <= 1'b0;
                        status_reg <= 1'b0;
                        created_reg <= '0;
                        state_reg <= S_GO;
                    end
                end
                S_GO:
                begin
                    unique case (cmd_reg)
                        fwrr_pkg::CMD_TICK:
                        begin
                            tick_reg <= tick_reg + 32'(period_reg);
                            f_reg <= head_reg[QI_SLEEP];
                            state_reg <= S_WALK;
                        end
                        fwrr_pkg::CMD_EVENT:
                        begin
                            f_reg <= head_reg[QI_WAIT];
                            state_reg <= S_WALK;
                        end
                        fwrr_pkg::CMD_SLEEP, fwrr_pkg::CMD_WAIT,
                        fwrr_pkg::CMD_RELEASE:
                        begin
                            s_reg <= LW'(cur_reg);
                            state_reg <= idle_reg ? S_RESCH : S_MRD;
                        end
                        fwrr_pkg::CMD_CREATE:
                        begin
                            if (head_reg[QI_FREE] == NIL)
                            begin
                                status_reg <= 1'b1;
                                state_reg <= S_OUT;
                            end
                            else
                            begin
                                s_reg <= head_reg[QI_FREE];
                                created_reg <= head_reg[QI_FREE][SW-1:0];
                                state_reg <= S_MRD;
                            end
                        end
                        fwrr_pkg::CMD_YIELD: state_reg <= S_RESCH;
                        default:             state_reg <= S_OUT;
                    endcase
                end
                S_WALK:
                    state_reg <= (f_reg == NIL) ? S_OUT : S_WDEC;
                S_WDEC:
                begin
                    f_reg <= rdata.nxt;
                    if (wake)
                    begin
                        s_reg <= f_reg;
                        p_reg <= rdata.prv;
                        n_reg <= rdata.nxt;
                        q_reg <= rdata.tag[1:0];
                        woken_reg <= woken_reg + CW'(1);
                        if (one_path && cmd_reg == fwrr_pkg::CMD_EVENT)
                            one_reg <= 1'b1;
                        state_reg <= S_DT1;
                    end
                    else
                        state_reg <= S_WALK;
                end
                S_MRD:
                    state_reg <= S_MDEC;
                S_MDEC:
                begin
                    p_reg <= rdata.prv;
                    n_reg <= rdata.nxt;
                    q_reg <= rdata.tag[1:0];
                    state_reg <= S_DT1;
                end
                S_DT1:
                begin
                    // unlink: fix predecessor or head, and tail
                    if (p_reg == NIL)
                        head_reg[q_reg] <= n_reg;
                    if (n_reg == NIL)
                        tail_reg[q_reg] <= p_reg;
                    state_reg <= S_DT2;
                end
                S_DT2:
                    state_reg <= S_AP1;
                S_AP1:
                begin
                    p_reg <= tail_reg[aq];
                    if (tail_reg[aq] == NIL)
                        head_reg[aq] <= s_reg;
                    tail_reg[aq] <= s_reg;
                    state_reg <= S_AP2;
                end
                S_AP2:
                begin
                    priority if (cmd_reg == fwrr_pkg::CMD_TICK ||
                                 cmd_reg == fwrr_pkg::CMD_EVENT)
                        state_reg <= S_WALK;
                    else if (cmd_reg == fwrr_pkg::CMD_CREATE)
                        state_reg <= S_OUT;
                    else
                        state_reg <= S_RESCH;
                end
                S_RESCH:
                begin
                    priority if (head_reg[QI_RUN] == NIL || dr_reg)
                    begin
                        idle_reg <= 1'b1;
                        state_reg <= S_OUT;
                    end
                    else if (!idle_reg)
                        state_reg <= S_RSDEC;
                    else
                    begin
                        cur_reg <= head_reg[QI_RUN][SW-1:0];
                        idle_reg <= 1'b0;
                        state_reg <= S_OUT;
                    end
                end
                S_RSDEC:
                begin
                    if (rdata.tag == fwrr_pkg::Q_RUN && rdata.nxt != NIL)
                        cur_reg <= rdata.nxt[SW-1:0];
                    else
                        cur_reg <= head_reg[QI_RUN][SW-1:0];
                    idle_reg <= 1'b0;
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!out_valid || out_ready)
                    begin
                        out_valid <= 1'b1;
                        status <= status_reg;
                        running_slot <= idle_reg ? '0 : fwrr_pkg::SLOT_OUT_W'(cur_reg);
                        running_idle <= idle_reg;
                        woken_count <= fwrr_pkg::WOKEN_OUT_W'(woken_reg);
                        created_slot <= fwrr_pkg::SLOT_OUT_W'(created_reg);
                        run_queue_empty <= (head_reg[QI_RUN] == NIL);
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `FWRR_ASSERT(a_run_ends, clk, rst_n, (head_reg[QI_RUN] == NIL) == (tail_reg[QI_RUN] == NIL))
    `FWRR_ASSERT(a_idle_slot, clk, rst_n, (out_valid && running_idle) |-> (running_slot == '0))
    `FWRR_ASSERT(a_woken_max, clk, rst_n, out_valid |-> (woken_count <= 5'(FIBER_SLOTS)))
    `FWRR_ASSERT_ALWAYS(a_no_req_in_reset, clk, !rst_n |-> !in_ready)
endmodule
`default_nettype wire

// ===== dv/tb.sv =====
// Testbench for the fiber scheduler: directed and random commands, scoreboard check.
`timescale 1ns / 100ps
`default_nettype none

module tb;
    localparam int SLOTS = 16;
    localparam int NIL = SLOTS;
    localparam int RANDOM_REQUESTS = 1750;
    localparam logic [2:0] CMD_UNUSED = 3'd7;   // no command: reports state only
    localparam logic [2:0] Q_NONE = 3'd4;       // detached slot

    // One result of the scheduler.
    typedef struct packed {
        logic       status;
        logic [3:0] running_slot;
        logic       running_idle;
        logic [4:0] woken_count;
        logic [3:0] created_slot;
        logic       run_queue_empty;
    } sched_result_t;

    // Shadow of the scheduler: queues, contexts, registers.
    class sched_scoreboard;
        logic [9:0]  tick_period;
        logic [15:0] notify_id;
        logic [15:0] notify_one_id;
        logic [15:0] wild_src;
        logic [15:0] wild_val;
        int          nxt [SLOTS];
        int          prv [SLOTS];
        logic [2:0]  tag [SLOTS];
        logic [31:0] ctx [SLOTS];
        int          heads [4];
        int          cur;
        bit          idle;
        logic [31:0] ticks;
        sched_result_t pending [$];
        int          errors;

        function void reset_state();
            tick_period = 10'd6;
            notify_id = 16'd1023;
            notify_one_id = 16'd1022;
            wild_src = 16'd0;
            wild_val = 16'd0;
            for (int i = 0; i < SLOTS; i++)
            begin
                ctx[i] = '0;
                tag[i] = fwrr_pkg::Q_FREE;
                nxt[i] = (i + 1 < SLOTS) ? i + 1 : NIL;
                prv[i] = (i > 1) ? i - 1 : NIL;
            end
            tag[0] = fwrr_pkg::Q_RUN;
            nxt[0] = NIL;
            prv[0] = NIL;
            heads[fwrr_pkg::Q_RUN] = 0;
            heads[fwrr_pkg::Q_SLEEP] = NIL;
            heads[fwrr_pkg::Q_WAIT] = NIL;
            heads[fwrr_pkg::Q_FREE] = 1;
            cur = 0;
            idle = 0;
            ticks = '0;
            errors = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [15:0] data);
            case (idx)
                fwrr_pkg::REG_TICK_PERIOD: tick_period = data[9:0];
                fwrr_pkg::REG_NOTIFY_ID:   notify_id = data;
                fwrr_pkg::REG_NOTIFY_ONE:  notify_one_id = data;
                fwrr_pkg::REG_WILD_SRC:    wild_src = data;
                fwrr_pkg::REG_WILD_VAL:    wild_val = data;
                default: ;
            endcase
        endfunction

        function void unlink(int s);
            int p;
            int n;
            p = prv[s];
            n = nxt[s];
            if (p < NIL) nxt[p] = n;
            else heads[tag[s]] = n;
            if (n < NIL) prv[n] = p;
            nxt[s] = NIL;
            prv[s] = NIL;
            tag[s] = Q_NONE;
        endfunction

        function void push_tail(int s, logic [2:0] q);
            int last;
            tag[s] = q;
            nxt[s] = NIL;
            if (heads[q] >= NIL)
            begin
                prv[s] = NIL;
                heads[q] = s;
            end
            else
            begin
                last = heads[q];
                while (nxt[last] < NIL) last = nxt[last];
                nxt[last] = s;
                prv[s] = last;
            end
        endfunction

        function void pick_next(bit dr);
            int head;
            head = heads[fwrr_pkg::Q_RUN];
            if (head >= NIL || dr)
            begin
                idle = 1;
                return;
            end
            if (!idle && tag[cur] == fwrr_pkg::Q_RUN)
                cur = (nxt[cur] < NIL) ? nxt[cur] : head;
            else
                cur = head;
            idle = 0;
        endfunction

        // Note an accepted request and queue its expected result.
        function void note_request(logic [2:0] c, logic [31:0] ms, logic [15:0] src,
                                   logic [15:0] val, bit dr);
            sched_result_t r;
            int f;
            int t;
            int woken;
            bit one_done;
            logic [15:0] id;
            logic [15:0] wv;
            bit vm;
            r = '0;
            woken = 0;
            case (c)
                fwrr_pkg::CMD_TICK:
                begin
                    ticks = ticks + 32'(tick_period);
                    f = heads[fwrr_pkg::Q_SLEEP];
                    while (f < NIL)
                    begin
                        t = nxt[f];
                        if (ticks >= ctx[f])
                        begin
                            unlink(f);
                            push_tail(f, fwrr_pkg::Q_RUN);
                            woken++;
                        end
                        f = t;
                    end
                end
                fwrr_pkg::CMD_EVENT:
                begin
                    one_done = 0;
                    f = heads[fwrr_pkg::Q_WAIT];
                    while (f < NIL)
                    begin
                        t = nxt[f];
                        id = ctx[f][15:0];
                        wv = ctx[f][31:16];
                        vm = (wv == wild_val) || (wv == val);
                        if (src == notify_one_id && id == notify_id && vm)
                        begin
                            if (!one_done)
                            begin
                                unlink(f);
                                push_tail(f, fwrr_pkg::Q_RUN);
                                woken++;
                                one_done = 1;
                            end
                        end
                        else if ((id == wild_src || id == src) && vm)
                        begin
                            unlink(f);
                            push_tail(f, fwrr_pkg::Q_RUN);
                            woken++;
                        end
                        f = t;
                    end
                end
                fwrr_pkg::CMD_SLEEP, fwrr_pkg::CMD_WAIT, fwrr_pkg::CMD_RELEASE:
                begin
                    if (!idle)
                    begin
                        unlink(cur);
                        if (c == fwrr_pkg::CMD_SLEEP)
                        begin
                            ctx[cur] = ticks + ms;
                            push_tail(cur, fwrr_pkg::Q_SLEEP);
                        end
                        else if (c == fwrr_pkg::CMD_WAIT)
                        begin
                            ctx[cur] = {val, src};
                            push_tail(cur, fwrr_pkg::Q_WAIT);
                        end
                        else
                            push_tail(cur, fwrr_pkg::Q_FREE);
                    end
                    pick_next(dr);
                end
                fwrr_pkg::CMD_CREATE:
                begin
                    f = heads[fwrr_pkg::Q_FREE];
                    if (f < NIL)
                    begin
                        unlink(f);
                        push_tail(f, fwrr_pkg::Q_RUN);
                        r.created_slot = f[3:0];
                    end
                    else
                        r.status = 1'b1;
                end
                fwrr_pkg::CMD_YIELD: pick_next(dr);
                default: ;
            endcase
            r.running_slot = idle ? 4'd0 : cur[3:0];
            r.running_idle = idle;
            r.woken_count = woken[4:0];
            r.run_queue_empty = (heads[fwrr_pkg::Q_RUN] >= NIL);
            pending.push_back(r);
        endfunction

        // Compare one accepted result with the oldest expectation.
        function void check_result(sched_result_t got);
            sched_result_t e;
            if (pending.size() == 0)
            begin
                $error("result with nothing expected: %p", got);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.status !== e.status)
            begin
                $error("status exp %0d got %0d", e.status, got.status);
                errors++;
            end
            if (got.running_slot !== e.running_slot)
            begin
                $error("running_slot exp %0d got %0d", e.running_slot, got.running_slot);
                errors++;
            end
            if (got.running_idle !== e.running_idle)
            begin
                $error("running_idle exp %0d got %0d", e.running_idle, got.running_idle);
                errors++;
            end
            if (got.woken_count !== e.woken_count)
            begin
                $error("woken_count exp %0d got %0d", e.woken_count, got.woken_count);
                errors++;
            end
            if (got.created_slot !== e.created_slot)
            begin
                $error("created_slot exp %0d got %0d", e.created_slot, got.created_slot);
                errors++;
            end
            if (got.run_queue_empty !== e.run_queue_empty)
            begin
                $error("run_queue_empty exp %0d got %0d", e.run_queue_empty,
                       got.run_queue_empty);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [2:0]  cmd = '0;
    logic [31:0] sleep_ms = '0;
    logic [15:0] event_source = '0;
    logic [15:0] event_value = '0;
    logic        data_ready = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        status;
    logic [3:0]  running_slot;
    logic        running_idle;
    logic [4:0]  woken_count;
    logic [3:0]  created_slot;
    logic        run_queue_empty;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_wdata = '0;

    sched_scoreboard sb;
    bit stall_free = 0;   // stretch with no idling on either side

    always #5 clk = ~clk;

    fiber_wake_and_round_robin_scheduler #(.FIBER_SLOTS(SLOTS)) DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .cmd(cmd), .sleep_ms(sleep_ms), .event_source(event_source),
        .event_value(event_value), .data_ready(data_ready),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .running_slot(running_slot), .running_idle(running_idle),
        .woken_count(woken_count), .created_slot(created_slot),
        .run_queue_empty(run_queue_empty),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    // Send one request; idle gap first, then hold valid until accepted.
    // Valid stays up after acceptance when the next request follows at once.
    task automatic send_request(logic [2:0] c, logic [31:0] ms, logic [15:0] src,
                                logic [15:0] val, bit dr);
        int gap;
        gap = stall_free ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd <= c;
        sleep_ms <= ms;
        event_source <= src;
        event_value <= val;
        data_ready <= dr;
        do @(posedge clk); while (!in_ready);
        sb.note_request(c, ms, src, val, dr);
    endtask

    // Wait until every result is back, plus a drain margin.
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (150) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        sb.write_reg(idx, data);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Random request biased toward meaningful ids/values so events and
    // notify channels actually wake waiters.
    task automatic random_request();
        logic [2:0]  c;
        logic [31:0] ms;
        logic [15:0] src;
        logic [15:0] val;
        int k;
        k = $urandom_range(0, 99);
        if (k < 18) c = fwrr_pkg::CMD_TICK;
        else if (k < 34) c = fwrr_pkg::CMD_EVENT;
        else if (k < 46) c = fwrr_pkg::CMD_SLEEP;
        else if (k < 60) c = fwrr_pkg::CMD_WAIT;
        else if (k < 74) c = fwrr_pkg::CMD_CREATE;
        else if (k < 82) c = fwrr_pkg::CMD_RELEASE;
        else if (k < 98) c = fwrr_pkg::CMD_YIELD;
        else c = CMD_UNUSED;
        case ($urandom_range(0, 3))
            0: ms = $urandom;
            1: ms = $urandom_range(0, 30);
            default: ms = $urandom_range(0, 3000);
        endcase
        case ($urandom_range(0, 5))
            0: src = 16'($urandom);
            1: src = sb.notify_id;
            2: src = sb.notify_one_id;
            3: src = sb.wild_src;
            default: src = 16'($urandom_range(1, 4));
        endcase
        case ($urandom_range(0, 4))
            0: val = 16'($urandom);
            1: val = sb.wild_val;
            default: val = 16'($urandom_range(1, 3));
        endcase
        send_request(c, ms, src, val, ($urandom_range(0, 7) == 0));
    endtask

    // Receiver: random stalls, sample results at the edge of acceptance.
    initial
    begin
        int stall;
        sched_result_t got;
        @(posedge rst_n);
        forever
        begin
            stall = stall_free ? 0 : $urandom_range(0, 6);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            got = '{status, running_slot, running_idle, woken_count,
                    created_slot, run_queue_empty};
            sb.check_result(got);
        end
    end

    initial
    begin
        sb = new();
        sb.reset_state();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        // Let the clearing pass finish; send_request waits on in_ready anyway.
        repeat (SLOTS + 4) @(posedge clk);

        // Directed: fill the pool, overflow create, every command, wildcards,
        // notify-one, idle-running parks, unknown command.
        write_reg(fwrr_pkg::REG_TICK_PERIOD, 16'd1);
        write_reg(fwrr_pkg::REG_NOTIFY_ID, 16'd1023);
        write_reg(fwrr_pkg::REG_NOTIFY_ONE, 16'd1022);
        write_reg(fwrr_pkg::REG_WILD_SRC, 16'd0);
        write_reg(fwrr_pkg::REG_WILD_VAL, 16'd0);
        repeat (16) send_request(fwrr_pkg::CMD_CREATE, '0, '0, '0, 0);
        send_request(fwrr_pkg::CMD_YIELD, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 0);
        send_request(fwrr_pkg::CMD_WAIT, '0, 16'd1023, 16'd5, 0);
        send_request(fwrr_pkg::CMD_WAIT, '0, 16'd1023, 16'd0, 0);
        send_request(fwrr_pkg::CMD_WAIT, '0, 16'd0, 16'd9, 0);
        send_request(fwrr_pkg::CMD_EVENT, '0, 16'd1022, 16'd5, 0);
        send_request(fwrr_pkg::CMD_EVENT, '0, 16'hFFFF, 16'd9, 0);
        send_request(fwrr_pkg::CMD_SLEEP, 32'd0, '0, '0, 0);
        send_request(fwrr_pkg::CMD_SLEEP, 32'hFFFF_FFFF, '0, '0, 0);
        send_request(fwrr_pkg::CMD_TICK, '0, '0, '0, 0);
        send_request(fwrr_pkg::CMD_YIELD, '0, '0, '0, 1);
        send_request(fwrr_pkg::CMD_RELEASE, '0, '0, '0, 1);
        send_request(fwrr_pkg::CMD_RELEASE, '0, '0, '0, 0);
        send_request(CMD_UNUSED, '0, '0, '0, 0);
        drain();

        // Random phases with differing register settings, extremes included.
        for (int ph = 0; ph < 7; ph++)
        begin
            case (ph)
                0: write_reg(fwrr_pkg::REG_TICK_PERIOD, 16'd1000);
                1:
                begin
                    write_reg(fwrr_pkg::REG_TICK_PERIOD, 16'hFFFF);
                    write_reg(fwrr_pkg::REG_WILD_SRC, 16'hFFFF);
                    write_reg(fwrr_pkg::REG_WILD_VAL, 16'hFFFF);
                end
                2:
                begin
                    write_reg(fwrr_pkg::REG_NOTIFY_ID, 16'd0);
                    write_reg(fwrr_pkg::REG_NOTIFY_ONE, 16'hFFFF);
                    write_reg(fwrr_pkg::REG_WILD_SRC, 16'd7);
                end
                3:
                begin
                    write_reg(fwrr_pkg::REG_TICK_PERIOD, 16'd37);
                    write_reg(fwrr_pkg::REG_NOTIFY_ID, 16'hFFFF);
                    write_reg(fwrr_pkg::REG_NOTIFY_ONE, 16'd0);
                    write_reg(fwrr_pkg::REG_WILD_VAL, 16'd2);
                end
                4:
                begin
                    write_reg(fwrr_pkg::REG_TICK_PERIOD, 16'($urandom_range(1, 1000)));
                    write_reg(fwrr_pkg::REG_NOTIFY_ID, 16'($urandom_range(1, 4)));
                    write_reg(fwrr_pkg::REG_NOTIFY_ONE, 16'($urandom_range(5, 8)));
                    write_reg(fwrr_pkg::REG_WILD_SRC, 16'd0);
                    write_reg(fwrr_pkg::REG_WILD_VAL, 16'd0);
                end
                default: write_reg(fwrr_pkg::REG_TICK_PERIOD, 16'($urandom_range(1, 1000)));
            endcase
            stall_free = (ph == 5);
            for (int n = 0; n < RANDOM_REQUESTS / 7; n++)
            begin
                // Hold off until the block is fully drained now and then.
                if (n == 100)
                begin
                    in_valid <= 1'b0;
                    while (sb.pending.size() != 0) @(posedge clk);
                end
                random_request();
            end
            stall_free = 0;
            drain();
        end
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("CHECK FAILED");
        $finish;
    end
endmodule

`default_nettype wire
